FILE: hw/rtl/eps_pkg.sv
// Shared types and constants of the EEPROM page burst splitter.
package eps_pkg;

	localparam int ADDR_W   = 25;   // running chunk address
	localparam int CNT_W    = 10;   // byte count, up to MAX_REQUEST_BYTES
	localparam int OFS_W    = 9;    // buffer offset
	localparam int PAGE_W   = 13;   // page size up to 4096
	localparam int MADDR_W  = 32;   // memory_address field
	localparam int S_TDATA_W = 48;  // start_address + byte_count, byte padded
	localparam int M_TDATA_W = 64;  // chunk fields, byte padded

	localparam logic [CNT_W-1:0] MAX_REQUEST_BYTES = 10'd512;

	// configuration register indexes
	localparam logic [1:0] REG_DEVICE_BASE = 2'd0;
	localparam logic [1:0] REG_ADDR_BYTES  = 2'd1;
	localparam logic [1:0] REG_PAGE_LOG2   = 2'd2;
	localparam logic [1:0] REG_MEM_LOG2    = 2'd3;

	// address byte counts after clamping
	localparam logic [2:0] AB_ONE   = 3'd1;
	localparam logic [2:0] AB_TWO   = 3'd2;
	localparam logic [2:0] AB_THREE = 3'd3;
	localparam logic [2:0] AB_FOUR  = 3'd4;

	// clamped configuration as seen by the datapath
	typedef struct packed {
		logic [7:0] dev_base;
		logic [2:0] addr_bytes;
		logic [3:0] page_log2;
	} cfg_t;

	// live work registers of the sequencer
	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  rem;
		logic [CNT_W-1:0]  done;
	} work_t;

	typedef struct packed {
		logic               op;
		logic [7:0]         dev_sel;
		logic [MADDR_W-1:0] mem_addr;
		logic [CNT_W-1:0]   len;
		logic [OFS_W-1:0]   offset;
		logic               last;
	} chunk_t;

	// one step of the chunk unit: the chunk and the advanced work registers
	typedef struct packed {
		chunk_t            chunk;
		logic [ADDR_W-1:0] next_addr;
		logic [CNT_W-1:0]  next_rem;
		logic [CNT_W-1:0]  next_done;
	} step_t;

endpackage

FILE: hw/rtl/eps_chunk_unit.sv
// Chunk unit: cuts the next page-bounded chunk from the work registers.
module eps_chunk_unit (
	input  eps_pkg::cfg_t  cfg,
	input  eps_pkg::work_t work,
	output eps_pkg::step_t step
);

	logic [eps_pkg::PAGE_W-1:0] page;
	logic [eps_pkg::PAGE_W-1:0] in_page;
	logic [eps_pkg::PAGE_W-1:0] room;
	logic [eps_pkg::PAGE_W-1:0] rem_ext;
	logic                       last;
	logic [eps_pkg::CNT_W-1:0]  len;
	logic [6:0]                 hi;
	logic [eps_pkg::MADDR_W-1:0] lo;

	always_comb begin
		page    = eps_pkg::PAGE_W'(1) << cfg.page_log2;
		in_page = work.addr[eps_pkg::PAGE_W-1:0] & (page - eps_pkg::PAGE_W'(1));
		room    = page - in_page;
		rem_ext = {3'b000, work.rem};
		last    = (room >= rem_ext);
		len     = last ? work.rem : room[eps_pkg::CNT_W-1:0];
	end

	// split of the chunk address around the address bytes
	always_comb begin
		case (cfg.addr_bytes)
			eps_pkg::AB_ONE: begin
				hi = work.addr[14:8];
				lo = {24'd0, work.addr[7:0]};
			end
			eps_pkg::AB_TWO: begin
				hi = work.addr[22:16];
				lo = {16'd0, work.addr[15:0]};
			end
			eps_pkg::AB_THREE: begin
				hi = {6'd0, work.addr[24]};
				lo = {8'd0, work.addr[23:0]};
			end
			default: begin
				hi = 7'd0;
				lo = {7'd0, work.addr};
			end
		endcase
	end

	always_comb begin
		step.chunk.op       = work.op;
		step.chunk.dev_sel  = cfg.dev_base | {hi, 1'b0};
		step.chunk.mem_addr = lo;
		step.chunk.len      = len;
		step.chunk.offset   = work.done[eps_pkg::OFS_W-1:0];
		step.chunk.last     = last;
		step.next_addr      = work.addr + {15'd0, len};
		step.next_rem       = work.rem - len;
		step.next_done      = work.done + len;
	end

endmodule

FILE: hw/rtl/eps_seq.sv
// Sequencer: holds work and output registers, one chunk per cycle unless stalled.
module eps_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            start_op,
	input  logic [eps_pkg::ADDR_W-1:0]      start_addr,
	input  logic [eps_pkg::CNT_W-1:0]       start_cnt,
	output logic                            idle,
	output eps_pkg::work_t                  work,
	input  eps_pkg::step_t                  step,
	output logic                            out_valid,
	input  logic                            out_ready,
	output eps_pkg::chunk_t                 out_chunk
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic            state_q;
	logic            out_valid_q;
	eps_pkg::work_t  work_q;
	eps_pkg::chunk_t out_q;
	logic            load;

	assign load = (state_q == ST_RUN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && (start_cnt != '0)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (load && step.chunk.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && (state_q == ST_IDLE)) begin
			work_q.op   <= start_op;
			work_q.addr <= start_addr;
			work_q.rem  <= start_cnt;
			work_q.done <= '0;
		end else if (load) begin
			work_q.addr <= step.next_addr;
			work_q.rem  <= step.next_rem;
			work_q.done <= step.next_done;
		end
		if (load) begin
			out_q <= step.chunk;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign work      = work_q;
	assign out_valid = out_valid_q;
	assign out_chunk = out_q;

endmodule

FILE: hw/rtl/eeprom_page_burst_splitter.sv
// Top level of the EEPROM page burst splitter.
// A request (operation on s_tuser, start address and byte count on s_tdata)
// is split into chunks that never cross an EEPROM write page. The start
// address is reduced modulo the memory size once; after that the chunk
// address only advances. Each chunk on the master side carries the device
// select byte, the low memory address bytes, its length and its offset in
// the caller's buffer; m_tlast marks the final chunk. A count of zero gives
// no chunks, and counts above 512 are cut to 512. Once a request is taken,
// the shared chunk unit cuts one chunk per cycle, and s_tready stays low
// until the final chunk of the request (up to 33 chunks) has been cut; the
// single output register sets the pace, and a stall on m_tready stalls the
// chunk unit with it. The next request may be taken while the final chunk
// still waits in the output register. Configuration writes (cfg_ready is
// always high) take effect on the next request and must only be made while
// no request is in flight.
module eeprom_page_burst_splitter (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [eps_pkg::S_TDATA_W-1:0] s_tdata, // [31:0] start_address, [41:32] byte_count
	input  logic        s_tuser,                   // [0] operation
	// chunk side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [eps_pkg::M_TDATA_W-1:0] m_tdata, // [7:0] device_select, [39:8] memory_address,
	                                               // [49:40] chunk_length, [58:50] buffer_offset
	output logic        m_tuser,                   // [0] chunk_operation
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// raw register values, clamped on use
	logic [7:0] dev_base_q;
	logic [2:0] addr_bytes_q;
	logic [3:0] page_log2_q;
	logic [4:0] mem_log2_q;

	eps_pkg::cfg_t   cfg;
	logic [4:0]      mem_log2;
	logic [eps_pkg::ADDR_W-1:0] start_addr;
	logic [eps_pkg::CNT_W-1:0]  req_cnt;
	logic [eps_pkg::CNT_W-1:0]  start_cnt;
	logic            idle;
	logic            start;
	eps_pkg::work_t  work;
	eps_pkg::step_t  step;
	eps_pkg::chunk_t out_chunk;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_base_q   <= 8'd160;
			addr_bytes_q <= 3'd2;
			page_log2_q  <= 4'd6;
			mem_log2_q   <= 5'd15;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				eps_pkg::REG_DEVICE_BASE: dev_base_q   <= cfg_data;
				eps_pkg::REG_ADDR_BYTES:  addr_bytes_q <= cfg_data[2:0];
				eps_pkg::REG_PAGE_LOG2:   page_log2_q  <= cfg_data[3:0];
				eps_pkg::REG_MEM_LOG2:    mem_log2_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// out-of-range settings snap to the nearest legal value
	always_comb begin
		cfg.dev_base = dev_base_q;
		if (addr_bytes_q == 3'd0) begin
			cfg.addr_bytes = eps_pkg::AB_ONE;
		end else if (addr_bytes_q > eps_pkg::AB_FOUR) begin
			cfg.addr_bytes = eps_pkg::AB_FOUR;
		end else begin
			cfg.addr_bytes = addr_bytes_q;
		end
		if (page_log2_q < 4'd4) begin
			cfg.page_log2 = 4'd4;
		end else if (page_log2_q > 4'd12) begin
			cfg.page_log2 = 4'd12;
		end else begin
			cfg.page_log2 = page_log2_q;
		end
		if (mem_log2_q < 5'd7) begin
			mem_log2 = 5'd7;
		end else if (mem_log2_q > 5'd24) begin
			mem_log2 = 5'd24;
		end else begin
			mem_log2 = mem_log2_q;
		end
	end

	// request intake: wrap into the memory, saturate the count
	always_comb begin
		start_addr = s_tdata[eps_pkg::ADDR_W-1:0] &
			((eps_pkg::ADDR_W'(1) << mem_log2) - eps_pkg::ADDR_W'(1));
		req_cnt    = s_tdata[41:32];
		start_cnt  = (req_cnt > eps_pkg::MAX_REQUEST_BYTES) ?
			eps_pkg::MAX_REQUEST_BYTES : req_cnt;
	end

	assign s_tready = idle;
	assign start    = s_tvalid && s_tready;

	eps_chunk_unit u_chunk (
		.cfg  (cfg),
		.work (work),
		.step (step)
	);

	eps_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_op   (s_tuser),
		.start_addr (start_addr),
		.start_cnt  (start_cnt),
		.idle       (idle),
		.work       (work),
		.step       (step),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_chunk  (out_chunk)
	);

	assign m_tdata = {5'd0, out_chunk.offset, out_chunk.len, out_chunk.mem_addr,
		out_chunk.dev_sel};
	assign m_tuser = out_chunk.op;
	assign m_tlast = out_chunk.last;

endmodule

FILE: hw/rtl/eps_check.sv
// Port-level checker for the EEPROM page burst splitter, bound to the top level.
module eps_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [eps_pkg::S_TDATA_W-1:0]   s_tdata,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [eps_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic                            m_tuser,
	input logic                            m_tlast,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [1:0]                      cfg_index,
	input logic [7:0]                      cfg_data
);

	// a stalled chunk holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("chunk changed while stalled");

	// a request with bytes keeps the block busy on the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata[41:32] != 10'd0) |=> !s_tready)
		else $error("request with bytes did not occupy the splitter");

	// more chunks are owed while a non-final chunk is shown
	a_busy_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("new request taken in the middle of a burst");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[49:40] != 10'd0))
		else $error("empty chunk");

endmodule

bind eeprom_page_burst_splitter eps_check u_eps_check (.*);
